// File: rtl/core/lavm_pkg.sv
// Shared constants, field widths and the translation saturation helper
// for the look-at view matrix unit. No dependencies.
package lavm_pkg;

   // Width of every input coordinate and of every translation result.
   localparam int COORD_W = 32;
   localparam int TRANS_W = 32;
   // Width of the unit-axis result fields.
   localparam int UNIT_W = 18;
   // Normalization scales the largest magnitude into [2^(NORM_W-1), 2^NORM_W).
   localparam int NORM_W = 30;
   // A rounded dot product fits in TRANS_W+3 bits; negation needs one more,
   // and the saturation input carries one spare bit on top of that.
   localparam int DOT_W = TRANS_W + 3;
   localparam int SAT_W = TRANS_W + 5;

   localparam logic signed [SAT_W-1:0] SAT_HI =
      {{(SAT_W-TRANS_W+1){1'b0}}, {(TRANS_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_LO =
      {{(SAT_W-TRANS_W+1){1'b1}}, {(TRANS_W-1){1'b0}}};

   // Clamps a wide signed value to the signed TRANS_W range.
   function automatic logic signed [TRANS_W-1:0] sat_trans(
      input logic signed [SAT_W-1:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[TRANS_W-1:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[TRANS_W-1:0];
      end else begin
         return v[TRANS_W-1:0];
      end
   endfunction

endpackage

// File: rtl/core/lavm_if.sv
// Valid/ready channel interfaces for the look-at view matrix unit.
// Depends on lavm_pkg for the field widths.
interface lavm_req_if;
   import lavm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] eye_x;
   logic signed [COORD_W-1:0] eye_y;
   logic signed [COORD_W-1:0] eye_z;
   logic signed [COORD_W-1:0] aim_x;
   logic signed [COORD_W-1:0] aim_y;
   logic signed [COORD_W-1:0] aim_z;
   logic signed [COORD_W-1:0] sky_x;
   logic signed [COORD_W-1:0] sky_y;
   logic signed [COORD_W-1:0] sky_z;

   modport source (output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                   sky_x, sky_y, sky_z, input ready);
   modport sink (input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                 sky_x, sky_y, sky_z, output ready);
endinterface

interface lavm_rsp_if;
   import lavm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [UNIT_W-1:0]  right_x;
   logic signed [UNIT_W-1:0]  right_y;
   logic signed [UNIT_W-1:0]  right_z;
   logic signed [UNIT_W-1:0]  upward_x;
   logic signed [UNIT_W-1:0]  upward_y;
   logic signed [UNIT_W-1:0]  upward_z;
   logic signed [UNIT_W-1:0]  back_x;
   logic signed [UNIT_W-1:0]  back_y;
   logic signed [UNIT_W-1:0]  back_z;
   logic signed [TRANS_W-1:0] shift_x;
   logic signed [TRANS_W-1:0] shift_y;
   logic signed [TRANS_W-1:0] shift_z;

   modport source (output valid, right_x, right_y, right_z, upward_x, upward_y,
                   upward_z, back_x, back_y, back_z, shift_x, shift_y, shift_z,
                   input ready);
   modport sink (input valid, right_x, right_y, right_z, upward_x, upward_y,
                 upward_z, back_x, back_y, back_z, shift_x, shift_y, shift_z,
                 output ready);
endinterface

// File: rtl/core/look_at_view_matrix_unit.sv
// Throughput: one transaction per cycle when the pipeline advances; the two normalizer
// pipelines (31-step square root and FRAC_BITS+1-step divider each) set the depth.
// The whole pipeline advances together whenever the output register is
// empty or being taken. Reset clears only the valid bits of every stage.
module look_at_view_matrix_unit #(
   parameter int FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   lavm_req_if.sink   req_port,
   lavm_rsp_if.source rsp_port
);
   import lavm_pkg::*;

   // Signed width of a unit axis component (range +-2^FRAC_BITS).
   localparam int FW    = FRAC_BITS + 2;
   localparam int DIF_W = COORD_W + 1;
   // Raw cross product of the forward axis and the world up vector.
   localparam int RCW   = FRAC_BITS + COORD_W + 2;
   // Axis component times a coordinate.
   localparam int PW    = FW + COORD_W;
   // Axis component times axis component.
   localparam int UW    = 2 * FW;
   // Sum of three axis-by-coordinate products.
   localparam int SW    = FRAC_BITS + COORD_W + 3;
   localparam int SIDE1 = 6 * COORD_W;
   localparam int SIDE2 = 3 * COORD_W + 3 * FW;

   localparam logic signed [SW-1:0] S_HALF    = SW'(1) << (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] S_HALF_M1 = S_HALF - SW'(1);
   localparam logic signed [UW-1:0] U_HALF    = UW'(1) << (FRAC_BITS - 1);
   localparam logic signed [UW-1:0] U_HALF_M1 = U_HALF - UW'(1);
   localparam logic signed [UW-1:0] U_ONE     = UW'(1) << FRAC_BITS;

   // The pipeline moves as one: every stage shifts when the response
   // register is empty or the consumer takes it this cycle.
   logic advance;
   assign advance        = !rsp_port.valid || rsp_port.ready;
   assign req_port.ready = advance;

   logic signed [COORD_W-1:0] req_eye [3];
   logic signed [COORD_W-1:0] req_aim [3];
   logic signed [COORD_W-1:0] req_sky [3];
   assign req_eye = '{req_port.eye_x, req_port.eye_y, req_port.eye_z};
   assign req_aim = '{req_port.aim_x, req_port.aim_y, req_port.aim_z};
   assign req_sky = '{req_port.sky_x, req_port.sky_y, req_port.sky_z};

   // Stage 0: register the transaction and form aim minus eye.
   logic                      t0_v_ff;
   logic signed [DIF_W-1:0]   dif_ff [3];
   logic [SIDE1-1:0]          t0_side_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            dif_ff[i] <= DIF_W'(req_aim[i]) - DIF_W'(req_eye[i]);
         end
         t0_side_ff <= {req_eye[0], req_eye[1], req_eye[2],
                        req_sky[0], req_sky[1], req_sky[2]};
      end
   end

   // Forward axis: f = normalize(aim - eye). Eye and sky ride along.
   logic                 n1_valid;
   logic signed [FW-1:0] n1_f [3];
   logic [SIDE1-1:0]     n1_side;

   lavm_norm #(
      .IN_W      (DIF_W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE1)
   ) u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (t0_v_ff),
      .in_vec    (dif_ff),
      .in_side   (t0_side_ff),
      .out_valid (n1_valid),
      .out_vec   (n1_f),
      .out_side  (n1_side)
   );

   logic signed [COORD_W-1:0] n1_eye [3];
   logic signed [COORD_W-1:0] n1_sky [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_eye[i] = n1_side[(5-i)*COORD_W +: COORD_W];
         n1_sky[i] = n1_side[(2-i)*COORD_W +: COORD_W];
      end
   end

   // Stage S1: the six partial products of cross(f, sky), full precision.
   logic                      s1_v_ff;
   logic signed [COORD_W-1:0] s1_eye_ff [3];
   logic signed [FW-1:0]      s1_f_ff   [3];
   logic signed [PW-1:0]      s1_p_ff   [6];

   // Stage S2: the raw right axis.
   logic                      s2_v_ff;
   logic signed [COORD_W-1:0] s2_eye_ff [3];
   logic signed [FW-1:0]      s2_f_ff   [3];
   logic signed [RCW-1:0]     s2_rc_ff  [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_eye_ff  <= n1_eye;
         s1_f_ff    <= n1_f;
         s1_p_ff[0] <= PW'(n1_f[1]) * PW'(n1_sky[2]);
         s1_p_ff[1] <= PW'(n1_f[2]) * PW'(n1_sky[1]);
         s1_p_ff[2] <= PW'(n1_f[2]) * PW'(n1_sky[0]);
         s1_p_ff[3] <= PW'(n1_f[0]) * PW'(n1_sky[2]);
         s1_p_ff[4] <= PW'(n1_f[0]) * PW'(n1_sky[1]);
         s1_p_ff[5] <= PW'(n1_f[1]) * PW'(n1_sky[0]);

         s2_eye_ff <= s1_eye_ff;
         s2_f_ff   <= s1_f_ff;
         for (int i = 0; i < 3; i++) begin
            s2_rc_ff[i] <= RCW'(s1_p_ff[2*i]) - RCW'(s1_p_ff[2*i+1]);
         end
      end
   end

   // Right axis: r = normalize(cross(f, sky)). Eye and f ride along.
   logic                 n2_valid;
   logic signed [FW-1:0] n2_r [3];
   logic [SIDE2-1:0]     n2_side;

   lavm_norm #(
      .IN_W      (RCW),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE2)
   ) u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_v_ff),
      .in_vec    (s2_rc_ff),
      .in_side   ({s2_eye_ff[0], s2_eye_ff[1], s2_eye_ff[2],
                   s2_f_ff[0], s2_f_ff[1], s2_f_ff[2]}),
      .out_valid (n2_valid),
      .out_vec   (n2_r),
      .out_side  (n2_side)
   );

   logic signed [COORD_W-1:0] n2_eye [3];
   logic signed [FW-1:0]      n2_f   [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n2_eye[i] = n2_side[3*FW + (2-i)*COORD_W +: COORD_W];
         n2_f[i]   = n2_side[(2-i)*FW +: FW];
      end
   end

   // Stage S3: partial products of cross(r, f) and of the two dot products
   // with the eye position.
   logic                      s3_v_ff;
   logic signed [COORD_W-1:0] s3_eye_ff [3];
   logic signed [FW-1:0]      s3_r_ff   [3];
   logic signed [FW-1:0]      s3_f_ff   [3];
   logic signed [UW-1:0]      s3_pu_ff  [6];
   logic signed [PW-1:0]      s3_pr_ff  [3];
   logic signed [PW-1:0]      s3_pf_ff  [3];

   // Stage S4: raw up axis and the two dot product sums.
   logic                      s4_v_ff;
   logic signed [COORD_W-1:0] s4_eye_ff [3];
   logic signed [FW-1:0]      s4_r_ff   [3];
   logic signed [FW-1:0]      s4_f_ff   [3];
   logic signed [UW-1:0]      s4_uraw_ff [3];
   logic signed [SW-1:0]      s4_dr_ff;
   logic signed [SW-1:0]      s4_df_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_eye_ff   <= n2_eye;
         s3_r_ff     <= n2_r;
         s3_f_ff     <= n2_f;
         s3_pu_ff[0] <= UW'(n2_r[1]) * UW'(n2_f[2]);
         s3_pu_ff[1] <= UW'(n2_r[2]) * UW'(n2_f[1]);
         s3_pu_ff[2] <= UW'(n2_r[2]) * UW'(n2_f[0]);
         s3_pu_ff[3] <= UW'(n2_r[0]) * UW'(n2_f[2]);
         s3_pu_ff[4] <= UW'(n2_r[0]) * UW'(n2_f[1]);
         s3_pu_ff[5] <= UW'(n2_r[1]) * UW'(n2_f[0]);
         for (int i = 0; i < 3; i++) begin
            s3_pr_ff[i] <= PW'(n2_r[i]) * PW'(n2_eye[i]);
            s3_pf_ff[i] <= PW'(n2_f[i]) * PW'(n2_eye[i]);
         end

         s4_eye_ff <= s3_eye_ff;
         s4_r_ff   <= s3_r_ff;
         s4_f_ff   <= s3_f_ff;
         for (int i = 0; i < 3; i++) begin
            s4_uraw_ff[i] <= s3_pu_ff[2*i] - s3_pu_ff[2*i+1];
         end
         s4_dr_ff <= SW'(s3_pr_ff[0]) + SW'(s3_pr_ff[1]) + SW'(s3_pr_ff[2]);
         s4_df_ff <= SW'(s3_pf_ff[0]) + SW'(s3_pf_ff[1]) + SW'(s3_pf_ff[2]);
      end
   end

   // Stage S5: round the up axis and both dot products half away from zero.
   // Adding half (or half minus one for negatives) before the arithmetic
   // shift gives that rounding in a single add.
   logic signed [UW-1:0]    ut_in [3];
   logic signed [UW-1:0]    ur_in [3];
   logic signed [FW-1:0]    u_in  [3];
   logic signed [SW-1:0]    drt_in;
   logic signed [SW-1:0]    dft_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ut_in[i] = s4_uraw_ff[i] + (s4_uraw_ff[i][UW-1] ? U_HALF_M1 : U_HALF);
         ur_in[i] = ut_in[i] >>> FRAC_BITS;
         if (ur_in[i] > U_ONE) begin
            u_in[i] = FW'(U_ONE);
         end else if (ur_in[i] < -U_ONE) begin
            u_in[i] = FW'(-U_ONE);
         end else begin
            u_in[i] = FW'(ur_in[i]);
         end
      end
      drt_in = s4_dr_ff + (s4_dr_ff[SW-1] ? S_HALF_M1 : S_HALF);
      dft_in = s4_df_ff + (s4_df_ff[SW-1] ? S_HALF_M1 : S_HALF);
   end

   logic                      s5_v_ff;
   logic signed [COORD_W-1:0] s5_eye_ff [3];
   logic signed [FW-1:0]      s5_r_ff   [3];
   logic signed [FW-1:0]      s5_f_ff   [3];
   logic signed [FW-1:0]      s5_u_ff   [3];
   logic signed [DOT_W-1:0]   s5_tr_ff;
   logic signed [DOT_W-1:0]   s5_tf_ff;

   // Stage S6: products of u and eye; saturate the x and z translations.
   logic                      s6_v_ff;
   logic signed [FW-1:0]      s6_r_ff   [3];
   logic signed [FW-1:0]      s6_f_ff   [3];
   logic signed [FW-1:0]      s6_u_ff   [3];
   logic signed [PW-1:0]      s6_pe_ff  [3];
   logic signed [TRANS_W-1:0] s6_shx_ff;
   logic signed [TRANS_W-1:0] s6_shz_ff;

   // Stage S7: up-axis dot product sum.
   logic                      s7_v_ff;
   logic signed [FW-1:0]      s7_r_ff   [3];
   logic signed [FW-1:0]      s7_f_ff   [3];
   logic signed [FW-1:0]      s7_u_ff   [3];
   logic signed [SW-1:0]      s7_du_ff;
   logic signed [TRANS_W-1:0] s7_shx_ff;
   logic signed [TRANS_W-1:0] s7_shz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_eye_ff <= s4_eye_ff;
         s5_r_ff   <= s4_r_ff;
         s5_f_ff   <= s4_f_ff;
         s5_u_ff   <= u_in;
         s5_tr_ff  <= DOT_W'(drt_in >>> FRAC_BITS);
         s5_tf_ff  <= DOT_W'(dft_in >>> FRAC_BITS);

         s6_r_ff   <= s5_r_ff;
         s6_f_ff   <= s5_f_ff;
         s6_u_ff   <= s5_u_ff;
         for (int i = 0; i < 3; i++) begin
            s6_pe_ff[i] <= PW'(s5_u_ff[i]) * PW'(s5_eye_ff[i]);
         end
         s6_shx_ff <= sat_trans(-SAT_W'(s5_tr_ff));
         s6_shz_ff <= sat_trans(SAT_W'(s5_tf_ff));

         s7_r_ff   <= s6_r_ff;
         s7_f_ff   <= s6_f_ff;
         s7_u_ff   <= s6_u_ff;
         s7_du_ff  <= SW'(s6_pe_ff[0]) + SW'(s6_pe_ff[1]) + SW'(s6_pe_ff[2]);
         s7_shx_ff <= s6_shx_ff;
         s7_shz_ff <= s6_shz_ff;
      end
   end

   // Stage S8 is the response register: round, negate and saturate the
   // y translation, and narrow the axes to the result field width.
   logic signed [SW-1:0]    dut_in;
   logic signed [DOT_W-1:0] tu_in;
   assign dut_in = s7_du_ff + (s7_du_ff[SW-1] ? S_HALF_M1 : S_HALF);
   assign tu_in  = DOT_W'(dut_in >>> FRAC_BITS);

   logic                      s8_v_ff;
   logic signed [UNIT_W-1:0]  right_ff [3];
   logic signed [UNIT_W-1:0]  up_ff    [3];
   logic signed [UNIT_W-1:0]  back_ff  [3];
   logic signed [TRANS_W-1:0] shift_ff [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            right_ff[i] <= UNIT_W'(s7_r_ff[i]);
            up_ff[i]    <= UNIT_W'(s7_u_ff[i]);
            back_ff[i]  <= UNIT_W'(-s7_f_ff[i]);
         end
         shift_ff[0] <= s7_shx_ff;
         shift_ff[1] <= sat_trans(-SAT_W'(tu_in));
         shift_ff[2] <= s7_shz_ff;
      end
   end

   // Valid bits of the stages outside the normalizers.
   always_ff @(posedge clock) begin
      if (reset) begin
         t0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
      end else if (advance) begin
         t0_v_ff <= req_port.valid;
         s1_v_ff <= n1_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= n2_valid;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
         s8_v_ff <= s7_v_ff;
      end
   end

   assign rsp_port.valid    = s8_v_ff;
   assign rsp_port.right_x  = right_ff[0];
   assign rsp_port.right_y  = right_ff[1];
   assign rsp_port.right_z  = right_ff[2];
   assign rsp_port.upward_x = up_ff[0];
   assign rsp_port.upward_y = up_ff[1];
   assign rsp_port.upward_z = up_ff[2];
   assign rsp_port.back_x   = back_ff[0];
   assign rsp_port.back_y   = back_ff[1];
   assign rsp_port.back_z   = back_ff[2];
   assign rsp_port.shift_x  = shift_ff[0];
   assign rsp_port.shift_y  = shift_ff[1];
   assign rsp_port.shift_z  = shift_ff[2];

endmodule

// File: rtl/core/lavm_norm.sv
// Pipelined 3-vector normalizer: magnitude scaling, sum of squares,
// digit-by-digit square root and restoring division. Depends on lavm_pkg.
module lavm_norm #(
   parameter int IN_W      = 33,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic signed [IN_W-1:0]      in_vec [3],
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+1:0] out_vec [3],
   output logic [SIDE_W-1:0]           out_side
);
   import lavm_pkg::*;

   localparam int K          = $clog2(IN_W);
   localparam int SH         = IN_W - NORM_W;
   localparam int SQ_W       = 2 * NORM_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int LEN_W      = ROOT_STEPS;
   localparam int QW         = FRAC_BITS + 1;
   localparam int FW         = FRAC_BITS + 2;
   localparam int DVW        = LEN_W + FRAC_BITS;
   localparam int TAG_W      = SIDE_W + 4;
   localparam int LAST       = K + ROOT_STEPS + QW + 3;

   // Tag layout: bit 0 zero vector, bits 3:1 component signs, rest sideband.
   logic              v_ff    [0:LAST];
   logic [TAG_W-1:0]  tag_ff  [0:LAST];
   logic [IN_W-1:0]   sm_ff   [0:K][3];
   logic [IN_W-1:0]   smx_ff  [0:K];
   logic [SQ_W-1:0]   sq_ff   [3];
   logic [NORM_W-1:0] mml_ff  [0:ROOT_STEPS+1][3];
   logic [SUM_W-1:0]  sx_ff   [0:ROOT_STEPS];
   logic [SUM_W-1:0]  sr_ff   [0:ROOT_STEPS];
   logic [DVW-1:0]    rem_ff  [0:FRAC_BITS][3];
   logic [QW-1:0]     q_ff    [0:FRAC_BITS][3];
   logic [LEN_W-1:0]  dl_ff   [0:FRAC_BITS];
   logic signed [FW-1:0] out_ff [3];

   logic [IN_W-1:0]   mag_in [3];
   logic [IN_W-1:0]   mx_in;
   logic [TAG_W-1:0]  tag_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
      end
      mx_in = mag_in[0];
      if (mag_in[1] > mx_in) begin
         mx_in = mag_in[1];
      end
      if (mag_in[2] > mx_in) begin
         mx_in = mag_in[2];
      end
      tag_in = {in_side, in_vec[2][IN_W-1], in_vec[1][IN_W-1], in_vec[0][IN_W-1],
                (mx_in == '0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p <= LAST; p++) begin
            v_ff[p] <= 1'b0;
         end
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int p = 1; p <= LAST; p++) begin
            v_ff[p] <= v_ff[p-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= tag_in;
         for (int p = 1; p <= LAST; p++) begin
            tag_ff[p] <= tag_ff[p-1];
         end
         for (int i = 0; i < 3; i++) begin
            sm_ff[0][i] <= mag_in[i];
         end
         smx_ff[0] <= mx_in;
      end
   end

   // Leading-zero shift, one binary step per stage, until the largest
   // magnitude has its top bit set.
   for (genvar j = 0; j < K; j++) begin : g_shift
      localparam int SA = 1 << (K - 1 - j);
      always_ff @(posedge clock) begin
         if (advance) begin
            if (smx_ff[j][IN_W-1 -: SA] == '0) begin
               smx_ff[j+1] <= smx_ff[j] << SA;
               for (int i = 0; i < 3; i++) begin
                  sm_ff[j+1][i] <= sm_ff[j][i] << SA;
               end
            end else begin
               smx_ff[j+1] <= smx_ff[j];
               for (int i = 0; i < 3; i++) begin
                  sm_ff[j+1][i] <= sm_ff[j][i];
               end
            end
         end
      end
   end

   // Drop the low bits so the largest magnitude lands in [2^29, 2^30),
   // then square and sum.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            mml_ff[0][i] <= NORM_W'(sm_ff[K][i] >> SH);
            sq_ff[i]     <= SQ_W'(NORM_W'(sm_ff[K][i] >> SH))
                          * SQ_W'(NORM_W'(sm_ff[K][i] >> SH));
         end
         sx_ff[0]  <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         sr_ff[0]  <= '0;
         mml_ff[1] <= mml_ff[0];
      end
   end

   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
      localparam logic [SUM_W:0] BIT = (SUM_W+1)'(1) << (SUM_W - 2 - 2 * j);
      logic [SUM_W:0] trial;
      assign trial = {1'b0, sr_ff[j]} + BIT;
      always_ff @(posedge clock) begin
         if (advance) begin
            if ({1'b0, sx_ff[j]} >= trial) begin
               sx_ff[j+1] <= sx_ff[j] - trial[SUM_W-1:0];
               sr_ff[j+1] <= (sr_ff[j] >> 1) + BIT[SUM_W-1:0];
            end else begin
               sx_ff[j+1] <= sx_ff[j];
               sr_ff[j+1] <= sr_ff[j] >> 1;
            end
            mml_ff[j+2] <= mml_ff[j+1];
         end
      end
   end

   // Restoring division, one quotient bit per stage, rounded to nearest
   // by the half-divisor added to the dividend.
   for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
      localparam int B = FRAC_BITS - k;
      logic [DVW-1:0]   rem_src [3];
      logic [QW-1:0]    q_src   [3];
      logic [LEN_W-1:0] len_src;
      logic [DVW-1:0]   sub;
      if (k == 0) begin : g_first
         assign len_src = sr_ff[ROOT_STEPS][LEN_W-1:0];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_src[i] = (DVW'(mml_ff[ROOT_STEPS+1][i]) << FRAC_BITS)
                              + DVW'(len_src >> 1);
            assign q_src[i]   = '0;
         end
      end else begin : g_next
         assign len_src = dl_ff[k-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_src[i] = rem_ff[k-1][i];
            assign q_src[i]   = q_ff[k-1][i];
         end
      end
      assign sub = DVW'(len_src) << B;
      always_ff @(posedge clock) begin
         if (advance) begin
            dl_ff[k] <= len_src;
            for (int i = 0; i < 3; i++) begin
               if (rem_src[i] >= sub) begin
                  rem_ff[k][i] <= rem_src[i] - sub;
                  q_ff[k][i]   <= q_src[i] | (QW'(1) << B);
               end else begin
                  rem_ff[k][i] <= rem_src[i];
                  q_ff[k][i]   <= q_src[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            if (tag_ff[LAST-1][0]) begin
               out_ff[i] <= '0;
            end else if (tag_ff[LAST-1][1+i]) begin
               out_ff[i] <= -$signed(FW'(q_ff[FRAC_BITS][i]));
            end else begin
               out_ff[i] <= $signed(FW'(q_ff[FRAC_BITS][i]));
            end
         end
      end
   end

   assign out_valid = v_ff[LAST];
   assign out_vec   = out_ff;
   assign out_side  = tag_ff[LAST][TAG_W-1:4];

endmodule

// File: rtl/core/lavm_checker.sv
// Port-level assertions for look_at_view_matrix_unit and the bind that
// attaches them. Depends on lavm_pkg and the top level.
module lavm_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [lavm_pkg::UNIT_W-1:0] back_x,
   input logic signed [lavm_pkg::TRANS_W-1:0] shift_y
);
   import lavm_pkg::*;

   localparam int ONE = 1 << FRAC_BITS;

   // No response may appear in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response stays valid and holds its back_x and shift_y values.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(back_x) && $stable(shift_y)))
      else $error("stalled response changed");

   // An empty response register always lets a request in.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // A waiting response blocks the input side.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while output stalled");

   if (FRAC_BITS <= 16) begin : g_range
      a_unit_range: assert property (@(posedge clock) disable iff (reset)
         rsp_valid |-> ((back_x <= ONE) && (back_x >= -ONE)))
         else $error("back axis outside unit range");
   end

endmodule

bind look_at_view_matrix_unit lavm_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_lavm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .back_x    (rsp_port.back_x),
   .shift_y   (rsp_port.shift_y)
);
